FILE: rtl/ema_pkg.sv
// Shared types, constants and control codes for the energy meter accumulator.
`timescale 1ns / 1ps

package ema_pkg;

  // Digit-serial datapath geometry.
  localparam int WORD_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  // Field and register widths.
  localparam int SAMPLE_W   = 10;
  localparam int CONST_W    = 16;
  localparam int TICKS_W    = 16;
  localparam int PULSE_W    = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int NUM_CHANNELS_DEF = 2;

  // Power formula constants.
  localparam logic [CONST_W-1:0] PWR_MUL     = 16'd61847;
  localparam int                 PWR_SHIFT   = 18;
  localparam int                 MAG_SHIFT   = 16;
  localparam logic [CONST_W-1:0] PULSE_WATTS = 16'd3600;
  localparam logic [1:0]         MS_SKIP     = 2'b11;

  // Register defaults.
  localparam logic [CONST_W-1:0] METER_CONST_RST    = 16'd1;
  localparam logic [WORD_W-1:0]  WATT_THRESHOLD_RST = 32'd1000000000;
  localparam logic [TICKS_W-1:0] SECOND_TICKS_RST   = 16'd625;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METER_CONST    = 2'd0,
    REG_WATT_THRESHOLD = 2'd1,
    REG_SECOND_TICKS   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Each pass walks all digits of a word once.
  typedef enum logic [2:0] {
    PASS_ACC,  // accumulate sample product, compare and pre-subtract threshold
    PASS_FIN,  // select final accumulator, bump energy count, period difference
    PASS_MAG,  // magnitude of the period difference
    PASS_MUL,  // power scaling product and pulse power product
    PASS_SUM   // combine pulse power with scaled difference
  } pass_t;

  typedef struct packed {
    logic  run;
    pass_t pass;
    logic  first;
    logic  last;
    logic  commit;
  } ctl_t;

endpackage

FILE: rtl/energy_meter_accumulator.sv
// Top level of the energy meter accumulator (two channels by default) with a digit-serial datapath.
`timescale 1ns / 1ps
// A result is registered after its sample transfer by five passes of eight 4-bit digit
// steps, then a commit that updates state and loads the output register once it is free.
// A new sample is taken only after the previous one has passed through the shared
// digit-serial adders and multipliers; the next sample is taken while a result waits.
// Reset clears all channel state, counters and the millisecond clock, and loads the
// register defaults; no clearing pass is needed.

module energy_meter_accumulator #(
  parameter int NUM_CHANNELS = ema_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: adc_sample [9:0], zeros above
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ema_pkg::IN_DATA_W-1:0]  s_tdata,
  // m_tdata: energy_pulse [0], energy_count [32:1], power_watts [64:33],
  // ms_time [96:65], zeros above
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ema_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: channel [0], power_valid [1]
  output logic [ema_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ema_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ema_pkg::WORD_W-1:0]     cfg_data
);
  import ema_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DW   = DIGIT_W;
  localparam int MA_W = WORD_W - MAG_SHIFT;

  ctl_t ctl;
  logic in_fire;
  logic out_free;

  // Configuration registers.
  logic [CONST_W-1:0] meter_const;
  logic [WORD_W-1:0]  watt_threshold;
  logic [TICKS_W-1:0] second_ticks;

  // Channel state.
  logic [WORD_W-1:0]  acc_q        [NUM_CHANNELS];
  logic [WORD_W-1:0]  snap_start_q [NUM_CHANNELS];
  logic [WORD_W-1:0]  snap_end_q   [NUM_CHANNELS];
  logic [PULSE_W-1:0] pin_q        [NUM_CHANNELS];
  logic [PULSE_W-1:0] plast_q      [NUM_CHANNELS];
  logic [WORD_W-1:0]  ecnt_q       [NUM_CHANNELS];
  logic [CH_W-1:0]    ch;
  logic [CH_W-1:0]    ch_next;
  logic [TICKS_W-1:0] round_cnt;
  logic [TICKS_W-1:0] round_inc;
  logic [TICKS_W-1:0] round_next;
  logic [WORD_W-1:0]  millis;
  logic               skip;

  // Working registers for the item in flight.
  logic [SAMPLE_W-1:0] smp;
  logic [WORD_W-1:0]   sr_a;   // accumulator, then sum, then final value
  logic [WORD_W-1:0]   sr_t;   // threshold
  logic [WORD_W-1:0]   sr_b;   // sum minus threshold
  logic [WORD_W-1:0]   sr_m;   // millisecond clock
  logic [WORD_W-1:0]   sr_e;   // energy count
  logic [WORD_W-1:0]   sr_s;   // previous period end snapshot
  logic [WORD_W-1:0]   sr_d;   // period difference, then its magnitude
  logic [WORD_W-1:0]   sr_p;   // scaling product, then the scaled difference
  logic [WORD_W-1:0]   sr_q;   // pulse power, then the power result
  logic [CONST_W-1:0]  sr_k;   // multiplier digits for the shared multiplier
  logic [CONST_W-1:0]  sr_c;   // pulse power constant digits
  logic [PULSE_W-1:0]  pulse_w;
  logic                gt;
  logic                neg;
  logic                snap;

  // Digit-serial unit connections.
  logic [DW-1:0] a0_x, a0_y, a0_s;
  logic [DW-1:0] a1_x, a1_y, a1_s;
  logic [DW-1:0] a2_s, a3_s;
  logic          a0_c, a1_c;
  logic          a0_co, a1_co, a2_co, a3_co;
  logic [MA_W-1:0]    m0_a;
  logic [DW-1:0]      m0_q, m1_q;
  logic          neg_now;
  logic [DW-1:0] fin_dig;
  logic [WORD_W-1:0] p_full;

  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  ema_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  always_comb begin
    neg_now = (ctl.pass == PASS_MAG && ctl.first) ? sr_d[WORD_W-1] : neg;
    fin_dig = gt ? sr_b[DW-1:0] : sr_a[DW-1:0];
    m0_a    = (ctl.pass == PASS_MUL) ? sr_d[WORD_W-1:MAG_SHIFT] : MA_W'(smp);
    a0_x = '0;
    a0_y = '0;
    a0_c = 1'b0;
    a1_x = '0;
    a1_y = '0;
    a1_c = 1'b0;
    case (ctl.pass)
      PASS_ACC: begin
        a0_x = sr_a[DW-1:0];
        a0_y = m0_q;
        a1_x = sr_t[DW-1:0];
        a1_y = ~a0_s;
        a1_c = 1'b1;
      end
      PASS_FIN: begin
        a0_x = sr_e[DW-1:0];
        a0_c = gt;
        a1_x = fin_dig;
        a1_y = ~sr_s[DW-1:0];
        a1_c = 1'b1;
      end
      PASS_MAG: begin
        // Two's complement negation when the difference is negative.
        a0_x = sr_d[DW-1:0] ^ {DW{neg_now}};
        a0_c = neg_now;
      end
      PASS_SUM: begin
        a0_x = sr_q[DW-1:0];
        a0_y = sr_p[DW-1:0] ^ {DW{neg}};
        a0_c = neg;
      end
      default: begin
        a0_x = '0;
      end
    endcase
  end

  ema_dsadd u_add0 (
    .clk(clk), .en(ctl.run), .first(ctl.first), .cin0(a0_c),
    .x(a0_x), .y(a0_y), .s(a0_s), .cout(a0_co)
  );

  ema_dsadd u_add1 (
    .clk(clk), .en(ctl.run), .first(ctl.first), .cin0(a1_c),
    .x(a1_x), .y(a1_y), .s(a1_s), .cout(a1_co)
  );

  // Sum minus threshold, kept in case the threshold is crossed.
  ema_dsadd u_add2 (
    .clk(clk), .en(ctl.run), .first(ctl.first), .cin0(1'b1),
    .x(a0_s), .y(~sr_t[DW-1:0]), .s(a2_s), .cout(a2_co)
  );

  ema_dsadd u_add3 (
    .clk(clk), .en(ctl.run), .first(ctl.first), .cin0(!skip),
    .x(sr_m[DW-1:0]), .y('0), .s(a3_s), .cout(a3_co)
  );

  ema_dsmul #(.A_W(MA_W)) u_mul0 (
    .clk(clk), .en(ctl.run), .first(ctl.first),
    .a(m0_a), .d(sr_k[DW-1:0]), .q(m0_q)
  );

  ema_dsmul #(.A_W(PULSE_W)) u_mul1 (
    .clk(clk), .en(ctl.run), .first(ctl.first),
    .a(pulse_w), .d(sr_c[DW-1:0]), .q(m1_q)
  );

  assign p_full = {m0_q, sr_p[WORD_W-1:DW]};

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp     <= s_tdata[SAMPLE_W-1:0];
      sr_a    <= acc_q[ch];
      sr_t    <= watt_threshold;
      sr_m    <= millis;
      sr_e    <= ecnt_q[ch];
      sr_s    <= snap_end_q[ch];
      sr_k    <= meter_const;
      sr_c    <= PULSE_WATTS;
      pulse_w <= pin_q[ch];
      snap    <= (round_cnt == second_ticks);
    end else if (ctl.run) begin
      case (ctl.pass)
        PASS_ACC: begin
          sr_a <= {a0_s, sr_a[WORD_W-1:DW]};
          sr_b <= {a2_s, sr_b[WORD_W-1:DW]};
          sr_t <= {{DW{1'b0}}, sr_t[WORD_W-1:DW]};
          sr_m <= {a3_s, sr_m[WORD_W-1:DW]};
          sr_k <= {{DW{1'b0}}, sr_k[CONST_W-1:DW]};
          if (ctl.last) begin
            // No carry out of threshold minus sum means the sum is above it.
            gt      <= !a1_co;
            pulse_w <= pulse_w + PULSE_W'(!a1_co);
          end
        end
        PASS_FIN: begin
          sr_a <= {fin_dig, sr_a[WORD_W-1:DW]};
          sr_b <= {{DW{1'b0}}, sr_b[WORD_W-1:DW]};
          sr_e <= {a0_s, sr_e[WORD_W-1:DW]};
          sr_s <= {{DW{1'b0}}, sr_s[WORD_W-1:DW]};
          sr_d <= {a1_s, sr_d[WORD_W-1:DW]};
        end
        PASS_MAG: begin
          sr_d <= {a0_s, sr_d[WORD_W-1:DW]};
          if (ctl.first) begin
            neg <= sr_d[WORD_W-1];
          end
          if (ctl.last) begin
            sr_k <= PWR_MUL;
          end
        end
        PASS_MUL: begin
          sr_k <= {{DW{1'b0}}, sr_k[CONST_W-1:DW]};
          sr_c <= {{DW{1'b0}}, sr_c[CONST_W-1:DW]};
          sr_q <= {m1_q, sr_q[WORD_W-1:DW]};
          if (ctl.last) begin
            sr_p <= p_full >> PWR_SHIFT;
          end else begin
            sr_p <= p_full;
          end
        end
        PASS_SUM: begin
          sr_p <= {{DW{1'b0}}, sr_p[WORD_W-1:DW]};
          sr_q <= {a0_s, sr_q[WORD_W-1:DW]};
        end
        default: begin
          sr_p <= sr_p;
        end
      endcase
    end
  end

  always_comb begin
    ch_next    = (ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch + 1'b1;
    round_inc  = (ch_next == '0) ? round_cnt + 1'b1 : round_cnt;
    round_next = (round_inc > second_ticks) ? '0 : round_inc;
  end

  // Configuration and channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      meter_const    <= METER_CONST_RST;
      watt_threshold <= WATT_THRESHOLD_RST;
      second_ticks   <= SECOND_TICKS_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        acc_q[i]        <= '0;
        snap_start_q[i] <= '0;
        snap_end_q[i]   <= '0;
        pin_q[i]        <= '0;
        plast_q[i]      <= '0;
        ecnt_q[i]       <= '0;
      end
      ch        <= '0;
      round_cnt <= '0;
      millis    <= '0;
      skip      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_METER_CONST:    meter_const    <= cfg_data[CONST_W-1:0];
          REG_WATT_THRESHOLD: watt_threshold <= cfg_data;
          REG_SECOND_TICKS:   second_ticks   <= cfg_data[TICKS_W-1:0];
          default:            meter_const    <= meter_const;
        endcase
      end
      if (ctl.commit) begin
        acc_q[ch]  <= sr_a;
        ecnt_q[ch] <= sr_e;
        if (snap) begin
          snap_start_q[ch] <= snap_end_q[ch];
          snap_end_q[ch]   <= sr_a;
          plast_q[ch]      <= pulse_w;
          pin_q[ch]        <= '0;
        end else begin
          pin_q[ch] <= pulse_w;
        end
        ch        <= ch_next;
        round_cnt <= round_next;
        millis    <= sr_m;
        skip      <= (sr_m[1:0] == MS_SKIP) && !skip;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      m_tdata <= {7'd0, sr_m, (snap ? sr_q : '0), sr_e, gt};
      m_tuser <= {snap, ch[0]};
    end
  end

  // A new result only appears after the sequencer has finished an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctl.commit))
    else $error("output valid rose without a commit");

  // No sample transfer is taken while the passes are running.
  assert property (@(posedge clk) disable iff (rst)
    ctl.run |-> !s_tready)
    else $error("input ready while the datapath is busy");

  // After a commit the block is ready for the next sample.
  assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> s_tready)
    else $error("sequencer did not return to idle after commit");

  // The channel pointer stays inside the configured channel count.
  assert property (@(posedge clk) disable iff (rst)
    32'(ch) < NUM_CHANNELS)
    else $error("channel pointer out of range");

endmodule

FILE: rtl/ema_dsadd.sv
// Digit-serial adder with a stored carry between digits.
`timescale 1ns / 1ps

module ema_dsadd (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        first,
  input  logic                        cin0,
  input  logic [ema_pkg::DIGIT_W-1:0] x,
  input  logic [ema_pkg::DIGIT_W-1:0] y,
  output logic [ema_pkg::DIGIT_W-1:0] s,
  output logic                        cout
);
  import ema_pkg::*;

  logic               carry;
  logic               c_in;
  logic [DIGIT_W:0]   sum;

  always_comb begin
    c_in = first ? cin0 : carry;
    sum  = {1'b0, x} + {1'b0, y} + {{DIGIT_W{1'b0}}, c_in};
    s    = sum[DIGIT_W-1:0];
    cout = sum[DIGIT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry <= cout;
    end
  end

endmodule

FILE: rtl/ema_dsmul.sv
// Digit-serial multiplier: parallel operand times a multiplier fed one digit per cycle while enabled.
`timescale 1ns / 1ps

module ema_dsmul #(
  parameter int A_W = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        first,
  input  logic [A_W-1:0]              a,
  input  logic [ema_pkg::DIGIT_W-1:0] d,
  output logic [ema_pkg::DIGIT_W-1:0] q
);
  import ema_pkg::*;

  localparam int PART_W = A_W + 1;
  localparam int SUM_W  = A_W + DIGIT_W + 1;

  logic [PART_W-1:0] part;
  logic [PART_W-1:0] part_in;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    part_in = first ? '0 : part;
    sum = SUM_W'(a) * SUM_W'(d) + SUM_W'(part_in);
    q   = sum[DIGIT_W-1:0];
  end

  // The partial sum carries the upper bits into the next digit position.
  always_ff @(posedge clk) begin
    if (en) begin
      part <= sum[SUM_W-1:DIGIT_W];
    end
  end

endmodule

FILE: rtl/ema_seq.sv
// Sequencer that steps the datapath through its passes and digits.
`timescale 1ns / 1ps

module ema_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_free,
  output logic            in_ready,
  output ema_pkg::ctl_t   ctl
);
  import ema_pkg::*;

  state_t                 state, state_next;
  pass_t                  pass, pass_next;
  logic [DIG_CNT_W-1:0]   dig, dig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= PASS_ACC;
      dig   <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      dig   <= dig_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    dig_next   = dig;
    in_ready   = 1'b0;
    ctl.run    = 1'b0;
    ctl.pass   = pass;
    ctl.first  = (dig == '0);
    ctl.last   = (dig == DIG_CNT_W'(NUM_DIGITS - 1));
    ctl.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          state_next = ST_RUN;
          pass_next  = PASS_ACC;
          dig_next   = '0;
        end
      end
      ST_RUN: begin
        ctl.run  = 1'b1;
        dig_next = dig + 1'b1;
        if (ctl.last) begin
          dig_next = '0;
          case (pass)
            PASS_ACC: pass_next = PASS_FIN;
            PASS_FIN: pass_next = PASS_MAG;
            PASS_MAG: pass_next = PASS_MUL;
            PASS_MUL: pass_next = PASS_SUM;
            default: begin
              pass_next  = PASS_ACC;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        // Results and state updates land together once the output register is free.
        if (out_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
